>>> hw/rtl/radix_integer_to_ascii_defines.svh
// Assertion macros for the radix integer-to-ASCII converter.
// They sample on clk_i and are disabled while rst_ni is low.
`ifndef RADIX_INTEGER_TO_ASCII_DEFINES_SVH
`define RADIX_INTEGER_TO_ASCII_DEFINES_SVH

// Property that must hold in the same cycle.
`define RITA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RITA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/rita_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rita_pkg
// Shared widths, constants, types and helpers of the integer-to-ASCII block.
// ----------------------------------------------------------------------------
package rita_pkg;

  localparam int unsigned ValueW           = 64;
  localparam int unsigned ValueBitsDefault = 64;
  localparam int unsigned RadixW           = 6;
  localparam int unsigned DigitW           = 6;
  localparam int unsigned CharW            = 8;
  localparam int unsigned CountW           = 7;
  localparam int unsigned MaxDigits        = 64;
  localparam int unsigned IdxW             = $clog2(MaxDigits);

  localparam int unsigned RadixMin   = 2;
  localparam int unsigned RadixMax   = 36;
  localparam int unsigned DecimalMax = 9;
  localparam int unsigned DecimalBase = 10;

  localparam logic [CharW-1:0] CharZero   = 8'h30;
  localparam logic [CharW-1:0] CharUpperA = 8'h41;
  localparam logic [CharW-1:0] CharLowerA = 8'h61;

  localparam logic [CountW-1:0] LastDigitIdx = CountW'(MaxDigits - 1);

  // Commands from the sequencer to the serial divider.
  typedef struct packed {
    logic load;    // take a new value and radix
    logic negate;  // replace the loaded value by its two's complement
    logic cont;    // run one more division pass on the quotient
  } rita_div_ctrl_t;

  // Result of one division pass.
  typedef struct packed {
    logic              done;
    logic              quot_zero;
    logic [DigitW-1:0] digit;
  } rita_div_status_t;

  function automatic logic [RadixW-1:0] radix_clamp(logic [RadixW-1:0] r);
    logic [RadixW-1:0] res;
    res = r;
    if (r < RadixW'(RadixMin)) res = RadixW'(RadixMin);
    if (r > RadixW'(RadixMax)) res = RadixW'(RadixMax);
    return res;
  endfunction

  function automatic logic [CharW-1:0] digit_ascii(logic [DigitW-1:0] d, logic upper);
    logic [CharW-1:0] base;
    logic [CharW-1:0] res;
    base = upper ? CharUpperA : CharLowerA;
    if (d <= DigitW'(DecimalMax)) begin
      res = CharZero + CharW'(d);
    end else begin
      res = base + CharW'(d) - CharW'(DecimalBase);
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/rita_div_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rita_div_unit
// Bit-serial magnitude and division unit: optional serial two's complement
// negation, then restoring division by the radix, one dividend bit a cycle.
// ----------------------------------------------------------------------------
module rita_div_unit import rita_pkg::*; #(
  parameter int unsigned VALUE_BITS = ValueBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rita_div_ctrl_t        ctrl_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [RadixW-1:0]     radix_i,
  output rita_div_status_t      status_o
);

  localparam int unsigned BitCntW = $clog2(VALUE_BITS);
  localparam logic [BitCntW-1:0] LastBit = BitCntW'(VALUE_BITS - 1);

  typedef enum logic [2:0] {
    DivIdle = 3'b001,
    DivNeg  = 3'b010,
    DivRun  = 3'b100
  } div_state_e;

  div_state_e            state_q, state_d;
  logic [BitCntW-1:0]    cnt_q, cnt_d;
  logic                  done_q, done_d;
  logic [VALUE_BITS-1:0] sh_q, sh_d;
  logic [DigitW-1:0]     rem_q, rem_d;
  logic [RadixW-1:0]     radix_q, radix_d;
  logic                  seen_q, seen_d;
  logic                  nz_q, nz_d;

  logic [DigitW:0] trial;
  logic [DigitW:0] diff;
  logic            ge;
  logic            neg_bit;

  assign trial   = {rem_q, sh_q[VALUE_BITS-1]};
  assign diff    = trial - {1'b0, radix_q};
  assign ge      = trial >= {1'b0, radix_q};
  // Copy bits up to and including the lowest one, invert the rest.
  assign neg_bit = seen_q ? ~sh_q[0] : sh_q[0];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    sh_d    = sh_q;
    rem_d   = rem_q;
    radix_d = radix_q;
    seen_d  = seen_q;
    nz_d    = nz_q;

    case (state_q)
      DivIdle: begin
      end
      DivNeg: begin
        sh_d   = {neg_bit, sh_q[VALUE_BITS-1:1]};
        seen_d = seen_q | sh_q[0];
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == LastBit) begin
          cnt_d   = '0;
          state_d = DivRun;
        end
      end
      DivRun: begin
        sh_d  = {sh_q[VALUE_BITS-2:0], ge};
        rem_d = ge ? diff[DigitW-1:0] : trial[DigitW-1:0];
        nz_d  = nz_q | ge;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastBit) begin
          cnt_d   = '0;
          done_d  = 1'b1;
          state_d = DivIdle;
        end
      end
      default: begin
        state_d = DivIdle;
      end
    endcase

    if (ctrl_i.load) begin
      sh_d    = value_i;
      radix_d = radix_i;
      rem_d   = '0;
      nz_d    = 1'b0;
      seen_d  = 1'b0;
      cnt_d   = '0;
      state_d = ctrl_i.negate ? DivNeg : DivRun;
    end else if (ctrl_i.cont) begin
      rem_d   = '0;
      nz_d    = 1'b0;
      cnt_d   = '0;
      state_d = DivRun;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DivIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q    <= sh_d;
    rem_q   <= rem_d;
    radix_q <= radix_d;
    seen_q  <= seen_d;
    nz_q    <= nz_d;
  end

  assign status_o.done      = done_q;
  assign status_o.quot_zero = ~nz_q;
  assign status_o.digit     = rem_q;

endmodule

>>> hw/rtl/radix_integer_to_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_integer_to_ascii
// Converts an integer to its ASCII digit string in a radix from 2 to 36.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the input channel (in_valid_i, in_stall_o) carries a value,
//   a signed selector, a radix, a letter case flag and an emit flag. Signed
//   values are converted as their magnitude; no sign is produced. With
//   emit_chars_i set, one result per digit leaves on the output channel
//   (out_valid_o, out_stall_i), most significant first, the last one marked
//   with last_o and carrying the digit count. With it clear, one result
//   carries only the count.
//   One request is processed at a time; in_stall_o stays high until its last
//   result has been loaded into the output register.
//   Per request: a negation pass (signed negative values only), then one
//   bit-serial division pass per digit, one dividend bit per cycle; then,
//   with emit_chars_i set, a read of the digit memory and a load of the
//   output for each digit.
//   Reset clears the sequencer and the output valid; the digit memory needs
//   no clearing. A stalled result holds in the output register and the
//   sequencer waits for it.
// ----------------------------------------------------------------------------
module radix_integer_to_ascii import rita_pkg::*; #(
  parameter int unsigned VALUE_BITS = ValueBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ValueW-1:0] value_i,
  input  logic              func_i,
  input  logic [RadixW-1:0] radix_i,
  input  logic              upper_case_i,
  input  logic              emit_chars_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CharW-1:0]  digit_char_o,
  output logic [CountW-1:0] digit_count_o,
  output logic              last_o
);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StDiv  = 4'b0010,
    StRead = 4'b0100,
    StOut  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              emit_q, emit_d;
  logic              upper_q, upper_d;
  logic              out_valid_q, out_valid_d;
  logic [DigitW-1:0] rd_data_q;
  logic [CharW-1:0]  char_q;
  logic [CountW-1:0] out_count_q;
  logic              last_q;

  logic [DigitW-1:0] digit_store_q [MaxDigits];

  rita_div_ctrl_t   div_ctrl;
  rita_div_status_t div_st;

  logic accept;
  logic out_load;
  logic last_now;
  logic wr_en;
  logic div_cont;

  assign accept   = in_valid_i && (state_q == StIdle);
  assign out_load = (state_q == StOut) && (!out_valid_q || !out_stall_i);
  assign last_now = !emit_q || (idx_q == '0);
  assign wr_en    = (state_q == StDiv) && div_st.done;

  assign div_ctrl.load   = accept;
  assign div_ctrl.negate = func_i & value_i[VALUE_BITS-1];
  assign div_ctrl.cont   = div_cont;

  rita_div_unit #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (div_ctrl),
    .value_i  (value_i[VALUE_BITS-1:0]),
    .radix_i  (radix_clamp(radix_i)),
    .status_o (div_st)
  );

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    emit_d   = emit_q;
    upper_d  = upper_q;
    div_cont = 1'b0;

    case (state_q)
      StIdle: begin
        if (accept) begin
          count_d = '0;
          emit_d  = emit_chars_i;
          upper_d = upper_case_i;
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (div_st.done) begin
          count_d = count_q + 1'b1;
          if (!div_st.quot_zero && (count_q != LastDigitIdx)) begin
            div_cont = 1'b1;
          end else begin
            // Most significant digit sits at the last written entry.
            idx_d   = count_q[IdxW-1:0];
            state_d = emit_q ? StRead : StOut;
          end
        end
      end
      StRead: begin
        state_d = StOut;
      end
      StOut: begin
        if (out_load) begin
          if (last_now) begin
            state_d = StIdle;
          end else begin
            idx_d   = idx_q - 1'b1;
            state_d = StRead;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    emit_q  <= emit_d;
    upper_q <= upper_d;
    if (out_load) begin
      char_q      <= emit_q ? digit_ascii(rd_data_q, upper_q) : '0;
      out_count_q <= last_now ? count_q : '0;
      last_q      <= last_now;
    end
  end

  // Digit memory: remainders land least significant first.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      digit_store_q[count_q[IdxW-1:0]] <= div_st.digit;
    end
    if (state_q == StRead) begin
      rd_data_q <= digit_store_q[idx_q];
    end
  end

  assign in_stall_o    = (state_q != StIdle);
  assign out_valid_o   = out_valid_q;
  assign digit_char_o  = char_q;
  assign digit_count_o = out_count_q;
  assign last_o        = last_q;

endmodule

>>> hw/rtl/rita_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rita_chk
// Port-level checks of the integer-to-ASCII converter, bound to the top.
// ----------------------------------------------------------------------------
`include "radix_integer_to_ascii_defines.svh"

module rita_chk import rita_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [CountW-1:0] digit_count_o,
  input logic              last_o
);

  logic count_ok;

  assign count_ok = (digit_count_o != '0) && (digit_count_o <= CountW'(MaxDigits));

  // A stalled result must stay offered.
  `RITA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped under stall")

  // One request at a time: the input closes right after an accept.
  `RITA_ASSERT_NEXT(a_in_busy, in_valid_i && !in_stall_o, in_stall_o, "input open after accept")

  // Only the final result of a conversion carries the count.
  `RITA_ASSERT(a_count_last, !(out_valid_o && !last_o) || (digit_count_o == '0), "count on non-final")

  // The final result reports between one and the maximum number of digits.
  `RITA_ASSERT(a_count_range, !(out_valid_o && last_o) || count_ok, "count out of range")

endmodule

bind radix_integer_to_ascii rita_chk u_rita_chk (.*);
